// ----- sv/rau_pkg.sv -----
// Package for the rational arithmetic unit: action codes, widths and defaults.
// No dependencies.
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam int ACT_W = 3;

    localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CMP = 3'd4;

endpackage

// ----- sv/rau_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on rau_pkg.
module rau_mul #(
    parameter int W = rau_pkg::OPERAND_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] prod
);
    import rau_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic           busy_reg;
    logic [CW-1:0]  cnt_reg;
    logic           done_reg;
    logic [2*W-1:0] acc_reg;
    logic [2*W-1:0] mcand_reg;
    logic [W-1:0]   mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // advance one multiplier bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= {{W{1'b0}}, a};
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[2*W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- sv/rau_gcd.sv -----
// Binary GCD: one halving or one compare-and-subtract per cycle, then the
// common power of two restored one shift per cycle. Depends on rau_pkg.
module rau_gcd #(
    parameter int MW = 2 * rau_pkg::OPERAND_WIDTH - 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [MW-1:0] x,
    input  logic [MW-1:0] y,
    output logic          done,
    output logic [MW-1:0] g
);
    import rau_pkg::*;

    localparam int KW = $clog2(MW + 1);

    logic          busy_reg;
    logic          shift_reg;
    logic          done_reg;
    logic [KW-1:0] k_reg;
    logic [MW-1:0] u_reg;
    logic [MW-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            shift_reg <= 1'b0;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                shift_reg <= 1'b0;
                k_reg     <= '0;
            end
            else if (busy_reg && shift_reg)
            begin
                k_reg <= k_reg - KW'(1);
                if (k_reg == KW'(1))
                begin
                    busy_reg  <= 1'b0;
                    shift_reg <= 1'b0;
                    done_reg  <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (v_reg == '0)
                begin
                    if (k_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                        shift_reg <= 1'b1;
                end
                else if (!u_reg[0] && !v_reg[0])
                    k_reg <= k_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            u_reg <= x;
            v_reg <= y;
        end
        else if (busy_reg && shift_reg)
            u_reg <= {u_reg[MW-2:0], 1'b0};
        else if (busy_reg && v_reg != '0)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= {1'b0, u_reg[MW-1:1]};
                v_reg <= {1'b0, v_reg[MW-1:1]};
            end
            else if (!u_reg[0])
                u_reg <= {1'b0, u_reg[MW-1:1]};
            else if (!v_reg[0])
                v_reg <= {1'b0, v_reg[MW-1:1]};
            else if (u_reg > v_reg)
            begin
                u_reg <= v_reg;
                v_reg <= u_reg - v_reg;
            end
            else
                v_reg <= v_reg - u_reg;
        end
    end

    assign done = done_reg;
    assign g    = u_reg;

endmodule

// ----- sv/rau_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_div #(
    parameter int MW = 2 * rau_pkg::OPERAND_WIDTH - 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [MW-1:0] dividend,
    input  logic [MW-1:0] divisor,
    output logic          done,
    output logic [MW-1:0] quot
);
    import rau_pkg::*;

    localparam int CW = $clog2(MW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [MW-1:0] rem_reg;
    logic [MW-1:0] quo_reg;
    logic [MW-1:0] dvs_reg;
    logic [MW:0]   trial;
    logic          ge;
    logic [MW:0]   diff;

    assign trial = {rem_reg, quo_reg[MW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(MW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[MW-1:0] : trial[MW-1:0];
            quo_reg <= {quo_reg[MW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ----- sv/rational_arith_unit_core.sv -----
// Rational arithmetic unit: add, subtract, multiply, divide and compare on two fractions,
// results reduced to lowest terms. Depends on rau_pkg, rau_mul, rau_gcd and rau_div.
// Sequence: three serial products, then the combining and magnitude steps, the binary GCD
// and the two dividers. Compare, divide by zero and unused codes finish at the combining
// step and a zero result at the magnitude step. One item at a time: the next beat is
// accepted at the edge ending the result beat. Reset idles the unit.
module rational_arith_unit_core #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [rau_pkg::ACT_W-1:0]      action,
    input  logic signed [OPERAND_WIDTH-1:0] a_numerator,
    input  logic [OPERAND_WIDTH-2:0]       a_denominator,
    input  logic signed [OPERAND_WIDTH-1:0] b_numerator,
    input  logic [OPERAND_WIDTH-2:0]       b_denominator,
    output logic                           done,
    output logic signed [rau_pkg::NUM_W-1:0] result_numerator,
    output logic [rau_pkg::DEN_W-1:0]      result_denominator,
    output logic                           less,
    output logic                           equal,
    output logic                           greater,
    output logic                           divide_by_zero
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;          // product width
    localparam int VW = 2 * W + 1;      // signed product / sum width
    localparam int MW = 2 * W - 1;      // magnitude width after combining
    localparam int OW = (MW + 1 > NUM_W) ? MW + 1 : NUM_W;

    // Sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MGO   = 4'd1;
    localparam logic [3:0] S_MWAIT = 4'd2;
    localparam logic [3:0] S_SIGN  = 4'd3;
    localparam logic [3:0] S_COMB  = 4'd4;
    localparam logic [3:0] S_MAG   = 4'd5;
    localparam logic [3:0] S_GGO   = 4'd6;
    localparam logic [3:0] S_GCD   = 4'd7;
    localparam logic [3:0] S_DGO   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  phase_reg;

    // Held operands of the accepted beat
    logic [ACT_W-1:0]  act_reg;
    logic signed [W-1:0] an_reg, bn_reg;
    logic [W-2:0]      ad_reg, bd_reg;

    logic [PW-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [VW-1:0] v0_reg, v1_reg, n_reg, d_reg;
    logic [MW-1:0] nmag_reg, dmag_reg;
    logic          neg_reg;

    // Output beat
    logic                    done_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    lt_reg, eq_reg, gt_reg, dz_reg;

    logic accept;
    assign accept = start && (state_reg == S_IDLE);

    // Operand magnitudes and signs
    logic          an_s, bn_s;
    logic [W-1:0]  an_m, bn_m;
    assign an_s = an_reg[W-1];
    assign bn_s = bn_reg[W-1];
    assign an_m = an_s ? W'(-an_reg) : W'(an_reg);
    assign bn_m = bn_s ? W'(-bn_reg) : W'(bn_reg);

    // Multiplier operand selection: phase 0 gives the left cross product
    // (or the numerator product for multiply), phase 1 the right cross
    // product, phase 2 the denominator product.
    logic [W-1:0] mul_a, mul_b;
    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                mul_a = an_m;
                mul_b = (act_reg == ACT_MUL) ? bn_m : {1'b0, bd_reg};
            end
            2'd1:
            begin
                mul_a = bn_m;
                mul_b = {1'b0, ad_reg};
            end
            default:
            begin
                mul_a = {1'b0, ad_reg};
                mul_b = {1'b0, bd_reg};
            end
        endcase
    end

    logic          mul_done;
    logic [PW-1:0] mul_prod;

    rau_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_MGO),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    logic          gcd_done;
    logic [MW-1:0] gcd_g;

    rau_gcd #(.MW(MW)) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_GGO),
        .x     (nmag_reg),
        .y     (dmag_reg),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    logic          divn_done, divd_done;
    logic [MW-1:0] qn, qd;

    rau_div #(.MW(MW)) u_divn (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DGO),
        .dividend (nmag_reg),
        .divisor  (gcd_g),
        .done     (divn_done),
        .quot     (qn)
    );

    rau_div #(.MW(MW)) u_divd (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DGO),
        .dividend (dmag_reg),
        .divisor  (gcd_g),
        .done     (divd_done),
        .quot     (qd)
    );

    // Combining stage: signed sum or difference of the cross products, else the left product
    logic signed [VW-1:0] sum_n, sum_d;
    logic                 sign0, sign1;
    always_comb
    begin
        sign0 = an_s ^ ((act_reg == ACT_MUL) && bn_s);
        sign1 = bn_s;
        case (act_reg)
            ACT_ADD: sum_n = VW'(v0_reg + v1_reg);
            ACT_SUB: sum_n = VW'(v0_reg - v1_reg);
            default: sum_n = v0_reg;
        endcase
        sum_d = (act_reg == ACT_DIV) ? v1_reg : VW'($signed({1'b0, p2_reg}));
    end

    // Final reduced values, sign moved into the numerator
    logic [OW-1:0] num_mag, num_full;
    assign num_mag  = {{(OW-MW){1'b0}}, qn};
    assign num_full = neg_reg ? OW'(-num_mag) : num_mag;

    // Finishing conditions
    logic fin_early, fin_zero, fin_div;
    assign fin_early = (state_reg == S_COMB) &&
                       ((act_reg == ACT_CMP) || (act_reg == ACT_DIV && bn_reg == '0) ||
                        (act_reg != ACT_ADD && act_reg != ACT_SUB &&
                         act_reg != ACT_MUL && act_reg != ACT_DIV));
    assign fin_zero  = (state_reg == S_MAG) && (n_reg == '0);
    assign fin_div   = (state_reg == S_DIV) && divn_done;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_MGO;
            S_MGO:   state_next = S_MWAIT;
            S_MWAIT: if (mul_done) state_next = (phase_reg == 2'd2) ? S_SIGN : S_MGO;
            S_SIGN:  state_next = S_COMB;
            S_COMB:  state_next = fin_early ? S_IDLE : S_MAG;
            S_MAG:   state_next = fin_zero ? S_IDLE : S_GGO;
            S_GGO:   state_next = S_GCD;
            S_GCD:   if (gcd_done) state_next = S_DGO;
            S_DGO:   state_next = S_DIV;
            S_DIV:   if (divn_done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin_early || fin_zero || fin_div;
            if (accept)
                phase_reg <= 2'd0;
            else if (state_reg == S_MWAIT && mul_done)
                phase_reg <= phase_reg + 2'd1;
        end
    end

    // Datapath registers: hold operands, capture products, combine
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            an_reg  <= a_numerator;
            ad_reg  <= a_denominator;
            bn_reg  <= b_numerator;
            bd_reg  <= b_denominator;
        end
        if (state_reg == S_MWAIT && mul_done)
        begin
            case (phase_reg)
                2'd0:    p0_reg <= mul_prod;
                2'd1:    p1_reg <= mul_prod;
                default: p2_reg <= mul_prod;
            endcase
        end
        if (state_reg == S_SIGN)
        begin
            v0_reg <= sign0 ? VW'(-$signed({1'b0, p0_reg})) : VW'($signed({1'b0, p0_reg}));
            v1_reg <= sign1 ? VW'(-$signed({1'b0, p1_reg})) : VW'($signed({1'b0, p1_reg}));
        end
        if (state_reg == S_COMB)
        begin
            n_reg <= sum_n;
            d_reg <= sum_d;
        end
        if (state_reg == S_MAG)
        begin
            nmag_reg <= n_reg[VW-1] ? MW'(-n_reg) : MW'(n_reg);
            dmag_reg <= d_reg[VW-1] ? MW'(-d_reg) : MW'(d_reg);
            neg_reg  <= n_reg[VW-1] ^ d_reg[VW-1];
        end

        // Result beat
        if (fin_early || fin_zero)
        begin
            num_reg <= '0;
            den_reg <= DEN_W'(1);
            lt_reg  <= (act_reg == ACT_CMP) && (v0_reg < v1_reg);
            eq_reg  <= (act_reg == ACT_CMP) && (v0_reg == v1_reg);
            gt_reg  <= (act_reg == ACT_CMP) && (v0_reg > v1_reg);
            dz_reg  <= (state_reg == S_COMB) && (act_reg == ACT_DIV) && (bn_reg == '0);
        end
        else if (fin_div)
        begin
            num_reg <= num_full[NUM_W-1:0];
            den_reg <= DEN_W'({{(OW-MW){1'b0}}, qd});
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            gt_reg  <= 1'b0;
            dz_reg  <= 1'b0;
        end
    end

    assign busy               = (state_reg != S_IDLE);
    assign done               = done_reg;
    assign result_numerator   = num_reg;
    assign result_denominator = den_reg;
    assign less               = lt_reg;
    assign equal              = eq_reg;
    assign greater            = gt_reg;
    assign divide_by_zero     = dz_reg;

    // Both dividers run in lockstep on the same divisor
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        divn_done == divd_done)
        else $error("dividers out of step");

    // The result beat lands with the sequencer back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // At most one compare or error flag per beat
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({less, equal, greater, divide_by_zero}))
        else $error("conflicting flags");

    // Flagged beats carry 0/1
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (less || equal || greater || divide_by_zero) |->
            result_numerator == '0 && result_denominator == DEN_W'(1))
        else $error("flagged beat carries a value");

    // An accepted beat keeps the unit busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accept did not start work");

endmodule
